// ===== hdl/address_interval_tracker_top_macros.svh =====
// Assertion macros shared by the tracker RTL.
`ifndef ADDRESS_INTERVAL_TRACKER_TOP_MACROS_SVH
`define ADDRESS_INTERVAL_TRACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define ATK_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("atk assertion failed");
// Property whose consequence must hold in the cycle after its cause.
`define ATK_ASSERT_NEXT(name, cause, effect) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("atk assertion failed");
`else
`define ATK_ASSERT_ALWAYS(name, expr)
`define ATK_ASSERT_NEXT(name, cause, effect)
`endif

`endif

// ===== hdl/atk_pkg.sv =====
package atk_pkg;

    localparam int CAPACITY     = 256;
    localparam int ADDRESS_BITS = 48;
    localparam int IDX_BITS     = $clog2(CAPACITY);
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int DELTA_BITS   = 50;
    localparam int ENTRY_BITS   = 2 * ADDRESS_BITS;

    localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

    // Operation codes
    localparam logic [1:0] KIND_MAP   = 2'd0;
    localparam logic [1:0] KIND_UNMAP = 2'd1;
    localparam logic [1:0] KIND_REMAP = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic [ADDRESS_BITS-1:0] start_address;
        logic [ADDRESS_BITS-1:0] length;
        logic [ADDRESS_BITS-1:0] new_address;
        logic [ADDRESS_BITS-1:0] new_length;
    } cmd_t;

    typedef struct packed {
        logic signed [DELTA_BITS-1:0] byte_delta;
        logic [8:0]                   live_count;
        logic                         table_full;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OP,
        ST_M_PRE,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_C_RD,
        ST_C_WR,
        ST_M_POST,
        ST_M_INS,
        ST_FIN
    } state_t;

endpackage

// ===== hdl/address_interval_tracker_top.sv =====
// Address interval tracker. Holds up to 256 non-overlapping intervals in an
// on-chip table (one synchronous RAM of start/end pairs plus a valid bit per
// slot) and processes one map, unmap or remap command at a time; cmd_stall
// stays high until the command's response has been formed. Each table walk
// skips an empty slot and, for an occupied one, reads the RAM, then evaluates
// and writes back, up to the current insert position, and then closes the walk.
// A map costs a walk plus an insert; an unmap one walk, with a nested map (its
// own walk, and possibly compactions) for the interval that it splits; a remap
// three walks. When the insert position hits the end of the table a compaction
// pass packs the occupied slots to the front. No clearing pass is needed after
// reset.
`include "address_interval_tracker_top_macros.svh"

module address_interval_tracker_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  atk_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output atk_pkg::rsp_t rsp
);

    localparam int AW = atk_pkg::ADDRESS_BITS;
    localparam int CW = atk_pkg::CNT_BITS;
    localparam int IW = atk_pkg::IDX_BITS;
    localparam int DW = atk_pkg::DELTA_BITS;
    localparam int EW = atk_pkg::ENTRY_BITS;

    atk_pkg::state_t state_reg, state_next;

    logic [1:0]              kind_reg, kind_next;
    logic [1:0]              step_reg, step_next;
    logic [AW-1:0]           s_reg, s_next, e_reg, e_next;
    logic [AW-1:0]           ns_reg, ns_next, ne_reg, ne_next;
    logic [AW-1:0]           cur_s_reg, cur_s_next, cur_e_reg, cur_e_next;
    logic                    is_map_reg, is_map_next;
    logic                    nest_reg, nest_next;
    logic [AW-1:0]           nest_s_reg, nest_s_next, nest_e_reg, nest_e_next;
    logic [CW-1:0]           idx_reg, idx_next, save_idx_reg, save_idx_next;
    logic [CW-1:0]           cw_reg, cw_next;
    logic                    comp_seen_reg, comp_seen_next;
    logic                    comp_ret_reg, comp_ret_next;
    logic [CW-1:0]           ins_reg, ins_next;
    logic [CW-1:0]           live_total_reg, live_total_next;
    logic [DW-1:0]           delta_reg, delta_next;
    logic                    drop_reg, drop_next;
    logic [atk_pkg::CAPACITY-1:0] valid_reg, valid_next;
    logic                    out_valid_reg, out_valid_next;
    atk_pkg::rsp_t           out_reg, out_next;

    // Interval RAM: {start, end}
    logic [EW-1:0] mem [atk_pkg::CAPACITY];
    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    // Range ends, saturated at the top of the address space
    logic [AW:0]   s_sum, ns_sum;
    logic [AW-1:0] s_end, ns_end;

    assign s_sum  = {1'b0, cmd.start_address} + {1'b0, cmd.length};
    assign ns_sum = {1'b0, cmd.new_address} + {1'b0, cmd.new_length};
    assign s_end  = s_sum[AW] ? {AW{1'b1}} : s_sum[AW-1:0];
    assign ns_end = ns_sum[AW] ? {AW{1'b1}} : ns_sum[AW-1:0];

    // Active range and overlap classes of the slot just read
    logic [AW-1:0] act_s, act_e, vs, ve;
    logic          c_split, c_left, c_right, c_whole;

    assign act_s = nest_reg ? nest_s_reg : cur_s_reg;
    assign act_e = nest_reg ? nest_e_reg : cur_e_reg;
    assign vs    = mem_rdata[EW-1:AW];
    assign ve    = mem_rdata[AW-1:0];

    assign c_split = (act_s > vs) && (act_e < ve);
    assign c_left  = (act_s <= vs) && (act_e > vs) && (act_e < ve);
    assign c_right = (act_s > vs) && (act_s < ve) && (act_e >= ve);
    assign c_whole = (act_s <= vs) && (act_e >= ve);

    // Command sequence: which operation comes next for this command
    logic          op_go, op_map;
    logic [AW-1:0] op_s, op_e;

    always_comb
    begin
        op_go  = 1'b0;
        op_map = 1'b0;
        op_s   = s_reg;
        op_e   = e_reg;
        case (kind_reg)
            atk_pkg::KIND_MAP:
            begin
                op_go  = (step_reg == 2'd0);
                op_map = 1'b1;
            end
            atk_pkg::KIND_UNMAP:
            begin
                op_go = (step_reg == 2'd0);
            end
            atk_pkg::KIND_REMAP:
            begin
                op_go  = (step_reg != 2'd3);
                op_map = (step_reg == 2'd2);
                if (step_reg != 2'd0)
                begin
                    op_s = ns_reg;
                    op_e = ne_reg;
                end
            end
            default:
            begin
                op_go = 1'b0;
            end
        endcase
    end

    logic idx_live, idx_valid, ins_full, out_free;

    assign idx_live  = idx_reg < ins_reg;
    assign idx_valid = valid_reg[idx_reg[IW-1:0]];
    assign ins_full  = ins_reg >= atk_pkg::CAP_CNT;
    assign out_free  = !out_valid_reg || !rsp_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atk_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = atk_pkg::ST_OP;
                end
            end
            atk_pkg::ST_OP:
            begin
                if (!op_go)
                begin
                    state_next = atk_pkg::ST_FIN;
                end
                else if (op_map)
                begin
                    state_next = atk_pkg::ST_M_PRE;
                end
                else
                begin
                    state_next = atk_pkg::ST_WALK_RD;
                end
            end
            atk_pkg::ST_M_PRE:
            begin
                state_next = ins_full ? atk_pkg::ST_C_RD : atk_pkg::ST_WALK_RD;
            end
            atk_pkg::ST_WALK_RD:
            begin
                if (!idx_live)
                begin
                    state_next = (nest_reg || is_map_reg) ? atk_pkg::ST_M_POST
                                                          : atk_pkg::ST_OP;
                end
                else if (idx_valid)
                begin
                    state_next = atk_pkg::ST_WALK_EV;
                end
            end
            atk_pkg::ST_WALK_EV:
            begin
                state_next = (c_split && !nest_reg) ? atk_pkg::ST_M_PRE
                                                    : atk_pkg::ST_WALK_RD;
            end
            atk_pkg::ST_C_RD:
            begin
                if (idx_reg == atk_pkg::CAP_CNT)
                begin
                    state_next = comp_ret_reg ? atk_pkg::ST_M_INS : atk_pkg::ST_WALK_RD;
                end
                else if (idx_valid)
                begin
                    state_next = atk_pkg::ST_C_WR;
                end
            end
            atk_pkg::ST_C_WR:
            begin
                state_next = atk_pkg::ST_C_RD;
            end
            atk_pkg::ST_M_POST:
            begin
                state_next = ins_full ? atk_pkg::ST_C_RD : atk_pkg::ST_M_INS;
            end
            atk_pkg::ST_M_INS:
            begin
                state_next = nest_reg ? atk_pkg::ST_WALK_RD : atk_pkg::ST_OP;
            end
            atk_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = atk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = atk_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and table updates
    always_comb
    begin
        kind_next       = kind_reg;
        step_next       = step_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        ns_next         = ns_reg;
        ne_next         = ne_reg;
        cur_s_next      = cur_s_reg;
        cur_e_next      = cur_e_reg;
        is_map_next     = is_map_reg;
        nest_next       = nest_reg;
        nest_s_next     = nest_s_reg;
        nest_e_next     = nest_e_reg;
        idx_next        = idx_reg;
        save_idx_next   = save_idx_reg;
        cw_next         = cw_reg;
        comp_seen_next  = comp_seen_reg;
        comp_ret_next   = comp_ret_reg;
        ins_next        = ins_reg;
        live_total_next = live_total_reg;
        delta_next      = delta_reg;
        drop_next       = drop_reg;
        valid_next      = valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[IW-1:0];
        mem_wdata       = mem_rdata;
        mem_raddr       = idx_reg[IW-1:0];

        case (state_reg)
            atk_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    kind_next  = cmd.kind;
                    s_next     = cmd.start_address;
                    e_next     = s_end;
                    ns_next    = cmd.new_address;
                    ne_next    = ns_end;
                    step_next  = 2'd0;
                    delta_next = '0;
                    drop_next  = 1'b0;
                    nest_next  = 1'b0;
                end
            end
            atk_pkg::ST_OP:
            begin
                cur_s_next  = op_s;
                cur_e_next  = op_e;
                is_map_next = op_map;
                step_next   = step_reg + 2'd1;
                idx_next    = '0;
            end
            atk_pkg::ST_M_PRE, atk_pkg::ST_M_POST:
            begin
                idx_next = '0;
                if (ins_full)
                begin
                    cw_next        = '0;
                    comp_ret_next  = (state_reg == atk_pkg::ST_M_POST);
                    comp_seen_next = comp_seen_reg || nest_reg;
                end
            end
            atk_pkg::ST_WALK_RD:
            begin
                if (idx_live && !idx_valid)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            atk_pkg::ST_WALK_EV:
            begin
                idx_next = idx_reg + 1'b1;
                if (c_split)
                begin
                    if (!nest_reg)
                    begin
                        // keep the left part, then insert the right part
                        mem_we         = 1'b1;
                        mem_wdata      = {vs, act_s};
                        delta_next     = delta_reg - DW'(act_e - act_s);
                        save_idx_next  = idx_reg;
                        idx_next       = idx_reg;
                        nest_next      = 1'b1;
                        nest_s_next    = act_e;
                        nest_e_next    = ve;
                        comp_seen_next = 1'b0;
                    end
                end
                else if (c_left)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {act_e, ve};
                    if (!nest_reg)
                    begin
                        delta_next = delta_reg - DW'(act_e - vs);
                    end
                end
                else if (c_right)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {vs, act_s};
                    if (!nest_reg)
                    begin
                        delta_next = delta_reg - DW'(ve - act_s);
                    end
                end
                else if (c_whole)
                begin
                    valid_next[idx_reg[IW-1:0]] = 1'b0;
                    if (live_total_reg != '0)
                    begin
                        live_total_next = live_total_reg - 1'b1;
                    end
                    if (!nest_reg)
                    begin
                        delta_next = delta_reg - DW'(ve - vs);
                    end
                end
            end
            atk_pkg::ST_C_RD:
            begin
                if (idx_reg == atk_pkg::CAP_CNT)
                begin
                    ins_next        = cw_reg;
                    live_total_next = cw_reg;
                    idx_next        = '0;
                end
                else if (!idx_valid)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            atk_pkg::ST_C_WR:
            begin
                // move occupied slot down to the write pointer
                if (cw_reg < idx_reg)
                begin
                    mem_we                     = 1'b1;
                    mem_waddr                  = cw_reg[IW-1:0];
                    valid_next[cw_reg[IW-1:0]] = 1'b1;
                    valid_next[idx_reg[IW-1:0]] = 1'b0;
                end
                cw_next  = cw_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            atk_pkg::ST_M_INS:
            begin
                if (ins_full)
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    mem_we                      = 1'b1;
                    mem_waddr                   = ins_reg[IW-1:0];
                    mem_wdata                   = {act_s, act_e};
                    valid_next[ins_reg[IW-1:0]] = 1'b1;
                    ins_next                    = ins_reg + 1'b1;
                    live_total_next             = live_total_reg + 1'b1;
                    if (!nest_reg)
                    begin
                        delta_next = delta_reg + DW'(act_e - act_s);
                    end
                end
                if (nest_reg)
                begin
                    nest_next = 1'b0;
                    idx_next  = comp_seen_reg ? '0 : save_idx_reg + 1'b1;
                end
            end
            atk_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.byte_delta   = delta_reg;
                    out_next.live_count   = 9'(live_total_reg);
                    out_next.table_full   = drop_reg;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= atk_pkg::ST_IDLE;
            nest_reg       <= 1'b0;
            ins_reg        <= '0;
            live_total_reg <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nest_reg       <= nest_next;
            ins_reg        <= ins_next;
            live_total_reg <= live_total_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        step_reg      <= step_next;
        s_reg         <= s_next;
        e_reg         <= e_next;
        ns_reg        <= ns_next;
        ne_reg        <= ne_next;
        cur_s_reg     <= cur_s_next;
        cur_e_reg     <= cur_e_next;
        is_map_reg    <= is_map_next;
        nest_s_reg    <= nest_s_next;
        nest_e_reg    <= nest_e_next;
        idx_reg       <= idx_next;
        save_idx_reg  <= save_idx_next;
        cw_reg        <= cw_next;
        comp_seen_reg <= comp_seen_next;
        comp_ret_reg  <= comp_ret_next;
        delta_reg     <= delta_next;
        drop_reg      <= drop_next;
        out_reg       <= out_next;
    end

    assign cmd_stall = (state_reg != atk_pkg::ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `ATK_ASSERT_ALWAYS(live_le_ins_a, live_total_reg <= ins_reg)
    `ATK_ASSERT_ALWAYS(ins_le_cap_a, ins_reg <= atk_pkg::CAP_CNT)
    `ATK_ASSERT_NEXT(nest_exit_a, (state_reg == atk_pkg::ST_M_INS) && nest_reg, !nest_reg)
    `ATK_ASSERT_NEXT(accept_busy_a, cmd_valid && !cmd_stall, state_reg == atk_pkg::ST_OP)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam logic [63:0] ADDR_TOP    = 64'h0000_FFFF_FFFF_FFFF;
    localparam int          CYCLE_LIMIT = 50000000;
    localparam int          HOLD_CYCLES = 4000;
    localparam int          DRAIN_WAIT  = 4000;
    localparam logic [47:0] B           = 48'h0000_2000_0000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    atk_pkg::cmd_t  cmd = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    atk_pkg::rsp_t  rsp;

    address_interval_tracker_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock: 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the interval table
    logic [63:0] shadow_lo [atk_pkg::CAPACITY];
    logic [63:0] shadow_hi [atk_pkg::CAPACITY];
    bit          shadow_live [atk_pkg::CAPACITY];
    int          shadow_count;
    int          shadow_ins;
    int          pack_epoch;
    bit          insert_dropped;

    atk_pkg::cmd_t  pending_cmds [$];
    atk_pkg::rsp_t  rsp_expect_q [$];
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    hold_request = 0;
    int    hold_seen = 0;
    int    hold_left = 0;
    int    fail_count = 0;
    int    transfers_in = 0;
    int    transfers_out = 0;
    int    drops_seen = 0;
    int    cycle_count = 0;

    function automatic void pack_table();
        int w;
        w = 0;
        for (int i = 0; i < atk_pkg::CAPACITY; i++)
        begin
            if (shadow_live[i])
            begin
                if (w < i)
                begin
                    shadow_lo[w]   = shadow_lo[i];
                    shadow_hi[w]   = shadow_hi[i];
                    shadow_live[w] = 1'b1;
                    shadow_lo[i]   = '0;
                    shadow_hi[i]   = '0;
                    shadow_live[i] = 1'b0;
                end
                w++;
            end
        end
        shadow_ins   = w;
        shadow_count = w;
        pack_epoch++;
    endfunction

    // Cut [s, e) out of every stored interval; returns bytes removed
    function automatic logic [63:0] cut_range(logic [63:0] s, logic [63:0] e);
        logic [63:0] removed;
        logic [63:0] lo;
        logic [63:0] hi;
        int          i;
        int          ep;
        removed = '0;
        i = 0;
        while (i < shadow_ins && i < atk_pkg::CAPACITY)
        begin
            if (shadow_live[i])
            begin
                lo = shadow_lo[i];
                hi = shadow_hi[i];
                if (s > lo && e < hi)
                begin
                    // split: left part stays, right part reinserted
                    ep = pack_epoch;
                    shadow_hi[i] = s;
                    removed += e - s;
                    void'(place_range(e, hi));
                    if (ep != pack_epoch)
                    begin
                        i = 0;
                        continue;
                    end
                end
                else if (s <= lo && e > lo && e < hi)
                begin
                    removed += e - lo;
                    shadow_lo[i] = e;
                end
                else if (s > lo && s < hi && e >= hi)
                begin
                    removed += hi - s;
                    shadow_hi[i] = s;
                end
                else if (s <= lo && e >= hi)
                begin
                    removed += hi - lo;
                    shadow_lo[i]   = '0;
                    shadow_hi[i]   = '0;
                    shadow_live[i] = 1'b0;
                    if (shadow_count > 0)
                        shadow_count--;
                end
            end
            i++;
        end
        return removed;
    endfunction

    // Map [s, e); returns net byte change
    function automatic logic [63:0] place_range(logic [63:0] s, logic [63:0] e);
        logic [63:0] removed;
        if (shadow_ins >= atk_pkg::CAPACITY)
            pack_table();
        removed = cut_range(s, e);
        if (shadow_ins >= atk_pkg::CAPACITY)
            pack_table();
        if (shadow_ins >= atk_pkg::CAPACITY)
        begin
            insert_dropped = 1'b1;
            return 64'd0 - removed;
        end
        shadow_lo[shadow_ins]   = s;
        shadow_hi[shadow_ins]   = e;
        shadow_live[shadow_ins] = 1'b1;
        shadow_ins++;
        shadow_count++;
        return (e - s) - removed;
    endfunction

    function automatic logic [63:0] clip_end(logic [47:0] s, logic [47:0] len);
        logic [63:0] e;
        e = {16'd0, s} + {16'd0, len};
        return (e > ADDR_TOP) ? ADDR_TOP : e;
    endfunction

    function automatic atk_pkg::rsp_t predict_rsp(atk_pkg::cmd_t c);
        logic [63:0]   s;
        logic [63:0]   e;
        logic [63:0]   ns;
        logic [63:0]   ne;
        logic [63:0]   delta;
        atk_pkg::rsp_t r;
        s  = {16'd0, c.start_address};
        e  = clip_end(c.start_address, c.length);
        ns = {16'd0, c.new_address};
        ne = clip_end(c.new_address, c.new_length);
        delta = '0;
        insert_dropped = 1'b0;
        case (c.kind)
            atk_pkg::KIND_MAP:   delta = place_range(s, e);
            atk_pkg::KIND_UNMAP: delta = 64'd0 - cut_range(s, e);
            atk_pkg::KIND_REMAP:
            begin
                delta = 64'd0 - cut_range(s, e);
                delta -= cut_range(ns, ne);
                delta += place_range(ns, ne);
            end
            default: delta = '0;
        endcase
        r.byte_delta = delta[atk_pkg::DELTA_BITS-1:0];
        r.live_count = shadow_count[8:0];
        r.table_full = insert_dropped;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h expected %h", $time, field, got, want);
        fail_count++;
    endtask

    // Append one command to the pending queue
    task automatic add_cmd(atk_pkg::cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Driver: present pending transfers, predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                rsp_expect_q.insert(rsp_expect_q.size(), predict_rsp(cmd));
                transfers_in++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    cmd       <= pending_cmds.pop_front();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: stall at random, check each accepted response
    always @(posedge clk)
    begin
        atk_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                transfers_out++;
                if (rsp_expect_q.size() == 0)
                begin
                    $display("[%0t] response with nothing expected", $time);
                    fail_count++;
                end
                else
                begin
                    want = rsp_expect_q.pop_front();
                    if (rsp.table_full)
                        drops_seen++;
                    if (rsp.byte_delta !== want.byte_delta)
                        report_mismatch("byte_delta", 64'(rsp.byte_delta),
                                        64'(want.byte_delta));
                    if (rsp.live_count !== want.live_count)
                        report_mismatch("live_count", 64'(rsp.live_count),
                                        64'(want.live_count));
                    if (rsp.table_full !== want.table_full)
                        report_mismatch("table_full", 64'(rsp.table_full),
                                        64'(want.table_full));
                end
            end
            rsp_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [47:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 48'({$urandom, $urandom});
        else if (r < 14)
            return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 255));
        return 48'h0000_1000_0000 + 48'($urandom_range(0, 8191));
    endfunction

    function automatic logic [47:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 48'({$urandom, $urandom});
        else if (r < 11)
            return '0;
        return 48'($urandom_range(1, 200));
    endfunction

    function automatic atk_pkg::cmd_t make_cmd(logic [1:0] k, logic [47:0] a,
                                               logic [47:0] l, logic [47:0] na,
                                               logic [47:0] nl);
        atk_pkg::cmd_t c;
        c.kind = k;
        c.start_address = a;
        c.length = l;
        c.new_address = na;
        c.new_length = nl;
        return c;
    endfunction

    function automatic atk_pkg::cmd_t random_cmd();
        int          r;
        logic [1:0]  k;
        r = $urandom_range(0, 99);
        if (r < 45)
            k = atk_pkg::KIND_MAP;
        else if (r < 80)
            k = atk_pkg::KIND_UNMAP;
        else if (r < 97)
            k = atk_pkg::KIND_REMAP;
        else
            k = ~atk_pkg::KIND_MAP;
        return make_cmd(k, pick_addr(), pick_len(), pick_addr(), pick_len());
    endfunction

    // Wait on settled values until nothing is pending or in flight
    task automatic drain();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || rsp_expect_q.size() != 0);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            add_cmd(random_cmd());
        drain();
    endtask

    // Stimulus sequence and end of run
    initial
    begin
        logic [1:0] unused_kind;
        unused_kind = ~atk_pkg::KIND_MAP;
        for (int i = 0; i < atk_pkg::CAPACITY; i++)
        begin
            shadow_lo[i] = '0;
            shadow_hi[i] = '0;
            shadow_live[i] = 1'b0;
        end
        shadow_count = 0;
        shadow_ins = 0;
        pack_epoch = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every kind, split, trims, zero length
        send_idle_pct = 34;
        recv_idle_pct = 66;
        add_cmd(make_cmd(atk_pkg::KIND_MAP, B, 48'd100, '1, '1));
        add_cmd(make_cmd(atk_pkg::KIND_UNMAP, B + 10, 48'd20, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_UNMAP, B, 48'd5, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_UNMAP, B + 90, 48'd50, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_UNMAP, B + 50, 48'd0, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_MAP, B + 500, 48'd0, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_UNMAP, B + 30, 48'd10, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_REMAP, B + 35, 48'd40, B + 1000, 48'd64));
        add_cmd(make_cmd(atk_pkg::KIND_MAP, '1, '1, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_MAP, 48'hFFFF_FFFF_FF00, '1, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_MAP, '0, '0, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_MAP, '0, '1, '0, '0));
        add_cmd(make_cmd(unused_kind, '1, '1, '1, '1));
        add_cmd(make_cmd(atk_pkg::KIND_MAP, B, 48'd300, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_REMAP, B + 10, 48'd10, '1, '1));
        add_cmd(make_cmd(atk_pkg::KIND_UNMAP, '0, '1, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_REMAP, '1, '0, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_UNMAP, '0, '1, '0, '0));
        drain();

        // Receiver holds off while sender keeps offering
        hold_request = 1;
        run_random(20);

        run_random(280);
        send_idle_pct = 66;
        recv_idle_pct = 34;
        run_random(280);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(100);

        // Fill the table with disjoint intervals until inserts drop
        add_cmd(make_cmd(atk_pkg::KIND_UNMAP, '0, '1, '0, '0));
        for (int i = 0; i < atk_pkg::CAPACITY + 6; i++)
            add_cmd(make_cmd(atk_pkg::KIND_MAP, B + 48'(i * 16),
                             48'($urandom_range(1, 8)), '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_UNMAP, B + 40, 48'd2, '0, '0));
        add_cmd(make_cmd(atk_pkg::KIND_REMAP, B + 80, 48'd1, B + 1, 48'd1));
        drain();
        run_random(120);

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("%0d commands sent, %0d responses checked, %0d dropped inserts seen",
                 transfers_in, transfers_out, drops_seen);
        $display("covered map/unmap/remap, splits, compaction, table full, stalls");
        if (fail_count == 0 && rsp_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
